>>> design/mclf_pkg.sv
// Shared types and constants for the modem command line front end.
// No dependencies; the top level, mclf_dp and mclf_ctrl import this package.
package mclf_pkg;

   // Line store geometry
   localparam int LINE_DEPTH = 40;
   localparam int ADDR_W     = $clog2(LINE_DEPTH);
   localparam int LEN_W      = $clog2(LINE_DEPTH + 1);

   // Configuration port geometry
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   // Fixed characters of the command prefix and replay
   localparam logic [7:0] CHAR_A     = 8'h41;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_T     = 8'h54;

   // Register reset values
   localparam logic [7:0] RST_ESCAPE    = 8'd43;
   localparam logic [7:0] RST_RETURN    = 8'd13;
   localparam logic [7:0] RST_LINEFEED  = 8'd10;
   localparam logic [7:0] RST_BACKSPACE = 8'd8;

   // Result codes
   localparam logic [2:0] RC_OK    = 3'd0;
   localparam logic [2:0] RC_ERROR = 3'd4;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ESCAPE    = 3'd0,
      CSR_RETURN    = 3'd1,
      CSR_LINEFEED  = 3'd2,
      CSR_BACKSPACE = 3'd3,
      CSR_ECHO      = 3'd4,
      CSR_QUIET     = 3'd5
   } csr_index_type;

   // Result item kinds
   typedef enum logic [2:0] {
      KIND_ECHO   = 3'd0,
      KIND_DATA   = 3'd1,
      KIND_RESULT = 3'd2,
      KIND_CHAR   = 3'd3,
      KIND_END    = 3'd4
   } kind_type;

   // What a command-mode byte does to the line
   typedef enum logic [2:0] {
      ACT_OTHER,
      ACT_START,
      ACT_STORE,
      ACT_RETURN,
      ACT_BKSP,
      ACT_FULL,
      ACT_REPLAY
   } action_type;

   // Source of the item pushed into the output register
   typedef enum logic [2:0] {
      EM_ECHO,
      EM_ESC,
      EM_DATA,
      EM_OK,
      EM_ERROR,
      EM_CHAR,
      EM_END
   } emit_type;

   // Controller to datapath
   typedef struct packed {
      logic     take;        // ready for a new item
      logic     set_online;  // apply a set-online request
      logic     esc_inc;     // count one more escape
      logic     esc_trip;    // third escape: back to command mode
      logic     esc_clear;   // escapes flushed
      logic     apply;       // apply the line action of a command byte
      logic     line_done;   // line end emitted
      logic     bk_read;     // read the new last character after backspace
      logic     bk_load;     // load that character as previous char
      logic     idx_inc;
      logic     idx_clear;
      logic     push;
      emit_type emit;
      logic     last;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic       is_set;
      logic       online;
      logic       is_esc;
      logic       esc_full;
      logic       quiet;
      logic       echo_now;
      logic       more_after_echo;
      action_type action;
      logic       idx_done;
      logic       out_free;
   } status_type;

endpackage

>>> design/mclf_if.sv
// Channel interfaces for the modem command line front end: request and response.
// Depends on nothing; valid/ready handshake with source and sink modports.
interface mclf_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] data_byte;
   logic       online_sel;

   modport source (output valid, output req_type, output data_byte, output online_sel,
                   input ready);
   modport sink (input valid, input req_type, input data_byte, input online_sel,
                 output ready);
endinterface

interface mclf_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] out_kind;
   logic [7:0] out_byte;
   logic [2:0] result_code;
   logic [5:0] line_length;
   logic       last;

   modport source (output valid, output out_kind, output out_byte, output result_code,
                   output line_length, output last, input ready);
   modport sink (input valid, input out_kind, input out_byte, input result_code,
                 input line_length, input last, output ready);
endinterface

>>> design/modem_command_line_front_end_unit.sv
// Top level of the modem command line front end: controller plus datapath.
// Depends on mclf_pkg, mclf_if, mclf_ctrl and mclf_dp.
//
// Usage: req_chan carries terminal bytes (req_type 0) or set-online requests
//   (req_type 1). rsp_chan returns echo, network data, result codes, command
//   characters and line ends; the final result of an item has last set.
//   csr_we/csr_index/csr_wdata write the six registers; write them while idle.
// Timing: one item is in work at a time; ready is high only between items.
//   A line replay reads its stored characters one at a time from the line
//   store's single read port.
// Reset: synchronous; restores the register defaults, command mode and an
//   empty line. The line store needs no clearing pass.
// Stalls: results wait in one output register; while that register is full and
//   rsp_chan.ready is low the sequencer holds at its next result. A new item
//   may be taken while the last result of the previous one still waits.
module modem_command_line_front_end_unit
   import mclf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   mclf_req_if.sink              req_chan,
   mclf_rsp_if.source            rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   mclf_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_chan.valid),
      .status   (status),
      .cmd      (cmd)
   );

   mclf_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .cmd      (cmd),
      .status   (status)
   );

endmodule

>>> design/mclf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mclf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 40
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> design/mclf_dp.sv
// Datapath of the modem command line front end: registers, mode state, line store,
// output register. Depends on mclf_pkg, mclf_if and mclf_ram.
module mclf_dp
   import mclf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   mclf_req_if.sink              req_chan,
   mclf_rsp_if.source            rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  cmd_type               cmd,
   output status_type            status
);

   // Configuration registers
   logic [7:0] esc_char_ff, ret_char_ff, lf_char_ff, bs_char_ff;
   logic       echo_en_ff, quiet_ff;

   // Mode and line state
   logic             online_ff, online_in;
   logic             collecting_ff, collecting_in;
   logic [7:0]       prev_char_ff, prev_char_in;
   logic [LEN_W-1:0] line_count_ff, line_count_in;
   logic [LEN_W-1:0] prev_line_ff, prev_line_in;
   logic [1:0]       esc_count_ff, esc_count_in;

   // Captured item
   logic       type_ff;
   logic [7:0] c_ff;
   logic       go_ff;

   // Emission index
   logic [LEN_W-1:0] idx_ff, idx_in;

   // Output register
   logic       out_valid_ff, out_valid_in;
   logic [2:0] out_kind_ff, out_kind_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic [2:0] out_code_ff, out_code_in;
   logic [5:0] out_len_ff, out_len_in;
   logic       out_last_ff;

   // Line store
   logic [ADDR_W-1:0] raddr;
   logic [7:0]        rd_data;
   logic              store_we;

   action_type       action;
   logic [LEN_W-1:0] line_len;
   logic [LEN_W-1:0] bk_addr;
   logic             accept;

   assign accept         = req_chan.valid && cmd.take;
   assign req_chan.ready = cmd.take;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         esc_char_ff <= RST_ESCAPE;
         ret_char_ff <= RST_RETURN;
         lf_char_ff  <= RST_LINEFEED;
         bs_char_ff  <= RST_BACKSPACE;
         echo_en_ff  <= 1'b1;
         quiet_ff    <= 1'b0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_ESCAPE:    esc_char_ff <= csr_wdata[7:0];
            CSR_RETURN:    ret_char_ff <= csr_wdata[7:0];
            CSR_LINEFEED:  lf_char_ff  <= csr_wdata[7:0];
            CSR_BACKSPACE: bs_char_ff  <= csr_wdata[7:0];
            CSR_ECHO:      echo_en_ff  <= csr_wdata[0];
            CSR_QUIET:     quiet_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Classify the held command-mode byte
   always_comb begin
      action = ACT_OTHER;
      if (collecting_ff) begin
         if (c_ff == ret_char_ff) begin
            action = ACT_RETURN;
         end else if (c_ff == bs_char_ff && line_count_ff != '0) begin
            action = ACT_BKSP;
         end else if (line_count_ff >= LEN_W'(LINE_DEPTH)) begin
            action = ACT_FULL;
         end else begin
            action = ACT_STORE;
         end
      end else if (prev_char_ff == CHAR_A) begin
         if (c_ff == CHAR_SLASH) begin
            action = ACT_REPLAY;
         end else if (c_ff == CHAR_T) begin
            action = ACT_START;
         end
      end
   end

   assign line_len = (action == ACT_RETURN) ? line_count_ff : prev_line_ff;
   assign bk_addr  = (line_count_ff >= LEN_W'(2)) ? line_count_ff - LEN_W'(2) : '0;

   // Status toward the controller
   always_comb begin
      status.is_set          = type_ff;
      status.online          = online_ff;
      status.is_esc          = (c_ff == esc_char_ff);
      status.esc_full        = (esc_count_ff >= 2'd2);
      status.quiet           = quiet_ff;
      status.echo_now        = echo_en_ff &&
                               !(c_ff == lf_char_ff && prev_char_ff == ret_char_ff);
      status.more_after_echo = (action == ACT_RETURN) || (action == ACT_REPLAY) ||
                               (action == ACT_FULL && !quiet_ff);
      status.action          = action;
      status.idx_done        = online_ff ? (idx_ff == LEN_W'(esc_count_ff))
                                         : (idx_ff == line_len);
      status.out_free        = !out_valid_ff || rsp_chan.ready;
   end

   // Next values of the mode and line state
   always_comb begin
      online_in     = online_ff;
      collecting_in = collecting_ff;
      prev_char_in  = prev_char_ff;
      line_count_in = line_count_ff;
      prev_line_in  = prev_line_ff;
      esc_count_in  = esc_count_ff;
      store_we      = 1'b0;

      if (cmd.set_online) begin
         online_in = go_ff;
      end
      if (cmd.esc_inc) begin
         esc_count_in = esc_count_ff + 2'd1;
      end
      if (cmd.esc_trip) begin
         esc_count_in = 2'd0;
         online_in    = 1'b0;
      end
      if (cmd.esc_clear) begin
         esc_count_in = 2'd0;
      end
      if (cmd.apply) begin
         case (action)
            ACT_BKSP: begin
               line_count_in = line_count_ff - LEN_W'(1);
            end
            ACT_FULL: begin
               collecting_in = 1'b0;
               line_count_in = '0;
               prev_line_in  = '0;
               prev_char_in  = c_ff;
            end
            ACT_STORE: begin
               store_we      = 1'b1;
               line_count_in = line_count_ff + LEN_W'(1);
               prev_char_in  = c_ff;
            end
            ACT_START: begin
               collecting_in = 1'b1;
               prev_char_in  = c_ff;
            end
            ACT_OTHER: begin
               prev_char_in = c_ff;
            end
            default: ;
         endcase
      end
      if (cmd.line_done) begin
         collecting_in = 1'b0;
         line_count_in = '0;
         prev_char_in  = c_ff;
         if (action == ACT_RETURN) begin
            prev_line_in = line_count_ff;
         end
      end
      if (cmd.bk_load && line_count_ff != '0) begin
         prev_char_in = rd_data;
      end
   end

   // Emission index; the read address looks one step ahead
   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + LEN_W'(1);
      end
      raddr = cmd.bk_read ? bk_addr[ADDR_W-1:0] : idx_in[ADDR_W-1:0];
   end

   // Output register: drop on take, load on push
   assign out_valid_in = cmd.push || (out_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         online_ff     <= 1'b0;
         collecting_ff <= 1'b0;
         prev_char_ff  <= 8'd0;
         line_count_ff <= '0;
         prev_line_ff  <= '0;
         esc_count_ff  <= 2'd0;
         idx_ff        <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         online_ff     <= online_in;
         collecting_ff <= collecting_in;
         prev_char_ff  <= prev_char_in;
         line_count_ff <= line_count_in;
         prev_line_ff  <= prev_line_in;
         esc_count_ff  <= esc_count_in;
         idx_ff        <= idx_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Capture the accepted item
   always_ff @(posedge clock) begin
      if (accept) begin
         type_ff <= req_chan.req_type;
         c_ff    <= req_chan.data_byte;
         go_ff   <= req_chan.online_sel;
      end
   end

   // Select the output payload
   always_comb begin
      out_kind_in = KIND_ECHO;
      out_byte_in = 8'd0;
      out_code_in = RC_OK;
      out_len_in  = 6'd0;
      case (cmd.emit)
         EM_ECHO: begin
            out_kind_in = KIND_ECHO;
            out_byte_in = c_ff;
         end
         EM_ESC: begin
            out_kind_in = KIND_DATA;
            out_byte_in = esc_char_ff;
         end
         EM_DATA: begin
            out_kind_in = KIND_DATA;
            out_byte_in = c_ff;
         end
         EM_OK: begin
            out_kind_in = KIND_RESULT;
         end
         EM_ERROR: begin
            out_kind_in = KIND_RESULT;
            out_code_in = RC_ERROR;
         end
         EM_CHAR: begin
            out_kind_in = KIND_CHAR;
            out_byte_in = rd_data;
         end
         EM_END: begin
            out_kind_in = KIND_END;
            out_len_in  = 6'(line_len);
         end
         default: begin
            out_kind_in = KIND_ECHO;
         end
      endcase
   end

   // Load the output payload
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         out_last_ff <= cmd.last;
         out_kind_ff <= out_kind_in;
         out_byte_ff <= out_byte_in;
         out_code_ff <= out_code_in;
         out_len_ff  <= out_len_in;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.out_kind    = out_kind_ff;
   assign rsp_chan.out_byte    = out_byte_ff;
   assign rsp_chan.result_code = out_code_ff;
   assign rsp_chan.line_length = out_len_ff;
   assign rsp_chan.last        = out_last_ff;

   mclf_ram #(
      .WIDTH(8),
      .DEPTH(LINE_DEPTH)
   ) u_line_store (
      .clock(clock),
      .we   (store_we),
      .waddr(line_count_ff[ADDR_W-1:0]),
      .wdata(c_ff),
      .raddr(raddr),
      .rdata(rd_data)
   );

endmodule

>>> design/mclf_ctrl.sv
// Controller of the modem command line front end: sequences each item's results.
// Depends on mclf_pkg.
module mclf_ctrl
   import mclf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_ECHO,
      ST_ACTION,
      ST_BK_LOAD,
      ST_LINE,
      ST_FLUSH,
      ST_RESULT
   } state_type;

   state_type state_ff, state_in;
   logic      err_ff, err_in;

   // Hold state and the pending result code
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         err_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         err_ff   <= err_in;
      end
   end

   // Decode commands and advance
   always_comb begin
      state_in = state_ff;
      err_in   = err_ff;
      cmd      = '0;
      cmd.emit = EM_ECHO;

      case (state_ff)
         ST_IDLE: begin
            cmd.take      = 1'b1;
            cmd.idx_clear = 1'b1;
            if (req_valid) begin
               state_in = ST_DISPATCH;
            end
         end

         ST_DISPATCH: begin
            if (status.is_set) begin
               cmd.set_online = 1'b1;
               state_in       = ST_IDLE;
            end else if (status.online) begin
               if (status.is_esc) begin
                  if (status.esc_full) begin
                     cmd.esc_trip = 1'b1;
                     err_in       = 1'b0;
                     state_in     = status.quiet ? ST_IDLE : ST_RESULT;
                  end else begin
                     cmd.esc_inc = 1'b1;
                     state_in    = ST_IDLE;
                  end
               end else begin
                  state_in = ST_FLUSH;
               end
            end else begin
               state_in = status.echo_now ? ST_ECHO : ST_ACTION;
            end
         end

         ST_ECHO: begin
            if (status.out_free) begin
               cmd.push = 1'b1;
               cmd.emit = EM_ECHO;
               cmd.last = !status.more_after_echo;
               state_in = ST_ACTION;
            end
         end

         ST_ACTION: begin
            cmd.apply = 1'b1;
            case (status.action)
               ACT_RETURN, ACT_REPLAY: begin
                  state_in = ST_LINE;
               end
               ACT_BKSP: begin
                  cmd.bk_read = 1'b1;
                  state_in    = ST_BK_LOAD;
               end
               ACT_FULL: begin
                  err_in   = 1'b1;
                  state_in = status.quiet ? ST_IDLE : ST_RESULT;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end

         ST_BK_LOAD: begin
            cmd.bk_load = 1'b1;
            state_in    = ST_IDLE;
         end

         // Stream stored characters, then the line end
         ST_LINE: begin
            if (status.out_free) begin
               cmd.push = 1'b1;
               if (!status.idx_done) begin
                  cmd.emit    = EM_CHAR;
                  cmd.idx_inc = 1'b1;
               end else begin
                  cmd.emit      = EM_END;
                  cmd.last      = 1'b1;
                  cmd.line_done = 1'b1;
                  cmd.idx_clear = 1'b1;
                  state_in      = ST_IDLE;
               end
            end
         end

         // Release held escapes, then the byte itself
         ST_FLUSH: begin
            if (status.out_free) begin
               cmd.push = 1'b1;
               if (!status.idx_done) begin
                  cmd.emit    = EM_ESC;
                  cmd.idx_inc = 1'b1;
               end else begin
                  cmd.emit      = EM_DATA;
                  cmd.last      = 1'b1;
                  cmd.esc_clear = 1'b1;
                  cmd.idx_clear = 1'b1;
                  state_in      = ST_IDLE;
               end
            end
         end

         ST_RESULT: begin
            if (status.out_free) begin
               cmd.push = 1'b1;
               cmd.emit = err_ff ? EM_ERROR : EM_OK;
               cmd.last = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
